// ===== src/tgq_pkg.sv =====
// ----------------------------------------------------------------------------
// tgq_pkg: shared types and constants
// Register map, threshold reset values and the press state record.
// ----------------------------------------------------------------------------
package tgq_pkg;

  localparam int AGE_W  = 16;
  localparam int CFG_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_LONG     = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_FADE     = 2'd2;
  localparam logic [1:0] REG_COOLDOWN = 2'd3;

  localparam logic [CFG_W-1:0] LONG_RST     = CFG_W'(2000);
  localparam logic [CFG_W-1:0] HOLD_RST     = CFG_W'(5000);
  localparam logic [CFG_W-1:0] FADE_RST     = CFG_W'(75);
  localparam logic [CFG_W-1:0] COOLDOWN_RST = CFG_W'(300);

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] hold_press_ms;
    logic [CFG_W-1:0] fade_ms;
    logic [CFG_W-1:0] cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic             press_active;
    logic             down_sent;
    logic             long_sent;
    logic             hold_sent;
    logic             cooling;
    logic [AGE_W-1:0] press_age;
    logic [AGE_W-1:0] silence_age;
    logic [AGE_W-1:0] cool_age;
  } press_t;

  typedef struct packed {
    logic ev_down;
    logic ev_long;
    logic ev_hold;
    logic ev_up;
    logic pressed;
  } result_t;

endpackage

// ===== src/touch_gesture_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// touch_gesture_qualifier_unit: touch long-press qualifier
// An accepted word passes through the input register, then the result register, to the output.
// One word per cycle while out_stall_i does not hold back a pending result.
// An input register and a result register decouple the two channels.
// Reset clears all press state and loads the default thresholds.
// ----------------------------------------------------------------------------
module touch_gesture_qualifier_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        touch_seen_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ev_down_o,
  output logic                        ev_long_o,
  output logic                        ev_hold_o,
  output logic                        ev_up_o,
  output logic                        pressed_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tgq_pkg::ADDR_W-1:0]  paddr,
  input  logic [tgq_pkg::DATA_W-1:0]  pwdata,
  output logic [tgq_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  tgq_pkg::cfg_t    cfg;
  tgq_pkg::result_t res, res_q;
  logic             in_valid_q, in_valid_d;
  logic             touch_q;
  logic             out_valid_q, out_valid_d;
  logic             advance;
  logic             in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      touch_q <= touch_seen_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  tgq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tgq_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .touch_i (touch_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign out_valid_o = out_valid_q;
  assign ev_down_o   = res_q.ev_down;
  assign ev_long_o   = res_q.ev_long;
  assign ev_hold_o   = res_q.ev_hold;
  assign ev_up_o     = res_q.ev_up;
  assign pressed_o   = res_q.pressed;

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && in_valid_q)
    else $error("input stalled without a pending result");

  a_up_ends_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.ev_up |=> out_valid_q && !res_q.pressed && !res_q.ev_down)
    else $error("release reported with press still active");

  a_down_is_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res.ev_down || res.ev_long || res.ev_hold) |-> res.pressed || res.ev_up)
    else $error("press event without an active press");

  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded");

endmodule

// ===== src/tgq_cfg.sv =====
// ----------------------------------------------------------------------------
// tgq_cfg: threshold registers
// APB-style register file holding the four millisecond thresholds.
// ----------------------------------------------------------------------------
module tgq_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tgq_pkg::ADDR_W-1:0]  paddr,
  input  logic [tgq_pkg::DATA_W-1:0]  pwdata,
  output logic [tgq_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tgq_pkg::cfg_t               cfg_o
);

  tgq_pkg::cfg_t    cfg_q, cfg_d;
  logic [1:0]       reg_idx;
  logic [tgq_pkg::CFG_W-1:0] wval;
  logic [tgq_pkg::CFG_W-1:0] rval;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wval    = pwdata[tgq_pkg::CFG_W-1:0];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        tgq_pkg::REG_LONG:     cfg_d.long_press_ms = wval;
        tgq_pkg::REG_HOLD:     cfg_d.hold_press_ms = wval;
        tgq_pkg::REG_FADE:     cfg_d.fade_ms       = wval;
        tgq_pkg::REG_COOLDOWN: cfg_d.cooldown_ms   = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tgq_pkg::REG_LONG:     rval = cfg_q.long_press_ms;
      tgq_pkg::REG_HOLD:     rval = cfg_q.hold_press_ms;
      tgq_pkg::REG_FADE:     rval = cfg_q.fade_ms;
      tgq_pkg::REG_COOLDOWN: rval = cfg_q.cooldown_ms;
      default:               rval = '0;
    endcase
  end

  assign prdata = tgq_pkg::DATA_W'(rval);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms <= tgq_pkg::LONG_RST;
      cfg_q.hold_press_ms <= tgq_pkg::HOLD_RST;
      cfg_q.fade_ms       <= tgq_pkg::FADE_RST;
      cfg_q.cooldown_ms   <= tgq_pkg::COOLDOWN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/tgq_core.sv =====
// ----------------------------------------------------------------------------
// tgq_core: press state update
// Advances the ages, applies the touch and judges the events for one tick.
// ----------------------------------------------------------------------------
module tgq_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              touch_i,
  input  tgq_pkg::cfg_t     cfg_i,
  output tgq_pkg::result_t  res_o
);

  tgq_pkg::press_t  st_q, st_d;
  tgq_pkg::result_t res;

  function automatic logic [tgq_pkg::AGE_W-1:0] sat_inc(
    input logic [tgq_pkg::AGE_W-1:0] a
  );
    logic [tgq_pkg::AGE_W-1:0] r;
    r = (a == '1) ? a : a + 1'b1;
    return r;
  endfunction

  function automatic logic exceeds(
    input logic [tgq_pkg::AGE_W-1:0] age,
    input logic [tgq_pkg::CFG_W-1:0] thr
  );
    logic r;
    r = 33'(age) > 33'(thr);
    return r;
  endfunction

  always_comb begin
    st_d = st_q;
    res  = '0;
    if (st_q.press_active) begin
      st_d.press_age   = sat_inc(st_q.press_age);
      st_d.silence_age = sat_inc(st_q.silence_age);
    end
    if (st_q.cooling) begin
      st_d.cool_age = sat_inc(st_q.cool_age);
    end
    if (touch_i) begin
      st_d.silence_age = '0;
      if (!st_q.press_active && !st_q.cooling) begin
        st_d.press_active = 1'b1;
        st_d.press_age    = '0;
      end
    end
    if (st_d.press_active) begin
      if (!st_d.down_sent) begin
        st_d.down_sent = 1'b1;
        res.ev_down    = 1'b1;
      end
      if (!st_d.long_sent && exceeds(st_d.press_age, cfg_i.long_press_ms)) begin
        st_d.long_sent = 1'b1;
        res.ev_long    = 1'b1;
      end
      if (!st_d.hold_sent && exceeds(st_d.press_age, cfg_i.hold_press_ms)) begin
        st_d.hold_sent = 1'b1;
        res.ev_hold    = 1'b1;
      end
      if (exceeds(st_d.silence_age, cfg_i.fade_ms)) begin
        st_d.press_active = 1'b0;
        st_d.down_sent    = 1'b0;
        st_d.long_sent    = 1'b0;
        st_d.hold_sent    = 1'b0;
        st_d.cooling      = 1'b1;
        st_d.cool_age     = '0;
        res.ev_up         = 1'b1;
      end
    end else if (st_d.cooling && exceeds(st_d.cool_age, cfg_i.cooldown_ms)) begin
      st_d.cooling = 1'b0;
    end
    res.pressed = st_d.press_active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign res_o = res;

endmodule
